@@ hdl/rlss_pkg.sv @@
// rlss_pkg: shared types and constants for the random looping shift sequencer
// no dependencies; used by the channel interfaces and the top level

package rlss_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOP_LENGTH    = 3'd0,
    CFG_FLIP_THRESHOLD = 3'd1,
    CFG_OUTPUT_LEVEL   = 3'd2,
    CFG_RANDOM_SEED    = 3'd3
  } cfg_idx_t;
  localparam int CFG_DATA_W = 32;

  // field widths
  localparam int LEN_W    = 5;
  localparam int LEVEL_W  = 16;
  localparam int NOISE_W  = 32;
  localparam int SCALE_W  = 12;
  localparam int PATOUT_W = 16;
  localparam int QUOT_W   = 16;

  // register reset values
  localparam logic [LEN_W-1:0]   LEN_RESET   = 5'd16;
  localparam logic [NOISE_W-1:0] FLIP_RESET  = 32'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'd16384;
  localparam logic [NOISE_W-1:0] SEED_RESET  = 32'd1;

  // xorshift32 shift amounts
  localparam int XS_A = 13;
  localparam int XS_B = 17;
  localparam int XS_C = 5;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  // one xorshift32 step
  function automatic logic [NOISE_W-1:0] xorshift(input logic [NOISE_W-1:0] x);
    logic [NOISE_W-1:0] y;
    y = x ^ (x << XS_A);
    y = y ^ (y >> XS_B);
    y = y ^ (y << XS_C);
    return y;
  endfunction

endpackage

@@ hdl/rlss_if.sv @@
// rlss channel interfaces: tick input, result output and config write
// depends on rlss_pkg

interface rlss_in_if;
  logic valid;
  logic ready;
  logic clock_level;
  logic reset_level;
  modport source (output valid, output clock_level, output reset_level, input ready);
  modport sink (input valid, input clock_level, input reset_level, output ready);
endinterface

interface rlss_out_if;
  import rlss_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [LEVEL_W-1:0]  bipolar_value;
  logic        [SCALE_W-1:0]  scale_bits;
  logic signed [LEVEL_W-1:0]  gate_value;
  logic        [PATOUT_W-1:0] pattern_bits;
  modport source (output valid, output bipolar_value, output scale_bits,
                  output gate_value, output pattern_bits, input ready);
  modport sink (input valid, input bipolar_value, input scale_bits,
                input gate_value, input pattern_bits, output ready);
endinterface

interface rlss_cfg_if;
  import rlss_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/random_looping_shift_sequencer_unit.sv @@
// random_looping_shift_sequencer_unit: looping shift register with random flips
// depends on rlss_pkg and the channel interfaces in rlss_if.sv
// an accepted tick word passes the multiply state, then the restoring divide state for
// each quotient bit, then the done state, which loads the result word when the receiver
// can take it; no new tick word is accepted until the unit returns to idle
// reset: synchronous rst clears pattern and edge state, loads register defaults
// and seeds the generator with one; config writes are taken every cycle

module random_looping_shift_sequencer_unit #(
  parameter int MAX_STEPS = 16
) (
  input logic        clk,
  input logic        rst,
  rlss_in_if.sink    samples,
  rlss_out_if.source results,
  rlss_cfg_if.sink   cfg
);
  import rlss_pkg::*;

  localparam int NB = $clog2(MAX_STEPS + 1);
  localparam int IW = $clog2(MAX_STEPS);
  localparam int NW = MAX_STEPS + 2;
  localparam int PW = LEVEL_W + MAX_STEPS;
  localparam int CW = $clog2(QUOT_W);

  // config registers
  logic        [LEN_W-1:0]   loop_length;
  logic        [NOISE_W-1:0] flip_threshold;
  logic signed [LEVEL_W-1:0] output_level;

  // sequencer state
  state_t                 state;
  logic [MAX_STEPS-1:0]   pattern;
  logic [NOISE_W-1:0]     noise;
  logic                   clock_prev;
  logic                   reset_prev;
  logic [PW-1:0]          rem;
  logic [PW-1:0]          dsr;
  logic [QUOT_W-1:0]      quot;
  logic [CW-1:0]          step;
  logic                   neg;
  logic                   out_valid;

  // loop length clamp and mask
  logic [NB-1:0]        steps;
  logic [MAX_STEPS-1:0] mask;
  always_comb begin
    if (loop_length == '0) begin
      steps = NB'(1);
    end else if (32'(loop_length) > MAX_STEPS) begin
      steps = NB'(MAX_STEPS);
    end else begin
      steps = NB'(loop_length);
    end
    mask = {MAX_STEPS{1'b1}} >> (NB'(MAX_STEPS) - steps);
  end

  // tick handling: reset edge, then clock edge shift
  logic                 accept;
  logic [MAX_STEPS-1:0] pat_cleared;
  logic [MAX_STEPS-1:0] pattern_next;
  logic [NOISE_W-1:0]   noise_word;
  logic                 top_bit;
  logic                 new_bit;
  logic                 clk_edge;
  assign accept     = samples.valid && samples.ready;
  assign noise_word = xorshift(noise);
  assign clk_edge   = samples.clock_level && !clock_prev;
  always_comb begin
    pat_cleared  = (samples.reset_level && !reset_prev) ? '0 : pattern;
    top_bit      = pat_cleared[IW'(steps - NB'(1))];
    new_bit      = (noise_word < flip_threshold) ? !top_bit : top_bit;
    pattern_next = clk_edge ? (((pat_cleared << 1) | MAX_STEPS'(new_bit)) & mask)
                            : pat_cleared;
  end

  // numerator 2*pattern - mask, clamped to mask, split into sign and magnitude
  logic signed [NW-1:0]  num_raw;
  logic signed [NW-1:0]  num_c;
  logic [MAX_STEPS-1:0]  num_mag;
  logic [LEVEL_W-1:0]    lev_mag;
  logic [PW-1:0]         prod;
  always_comb begin
    num_raw = $signed({1'b0, pattern, 1'b0}) - $signed({2'b00, mask});
    num_c   = (num_raw > $signed({2'b00, mask})) ? $signed({2'b00, mask}) : num_raw;
    num_mag = num_c[NW-1] ? MAX_STEPS'(-num_c) : MAX_STEPS'(num_c);
    lev_mag = output_level[LEVEL_W-1] ? LEVEL_W'(-output_level)
                                      : LEVEL_W'(output_level);
    prod    = PW'(lev_mag * num_mag);
  end

  // result word assembly
  logic signed [LEVEL_W-1:0] bip;
  logic        [PATOUT_W-1:0] pat16;
  always_comb begin
    if (neg) begin
      bip = $signed(LEVEL_W'(-quot));
    end else if (quot[QUOT_W-1]) begin
      bip = LEVEL_W'(16'sd32767);
    end else begin
      bip = $signed(quot);
    end
    pat16 = PATOUT_W'(pattern);
  end

  assign samples.ready = (state == ST_IDLE);
  assign cfg.ready     = 1'b1;
  assign results.valid = out_valid;

  // config writes and generator state
  always_ff @(posedge clk) begin
    if (rst) begin
      loop_length    <= LEN_RESET;
      flip_threshold <= FLIP_RESET;
      output_level   <= LEVEL_RESET;
      noise          <= SEED_RESET;
      pattern        <= '0;
      clock_prev     <= 1'b0;
      reset_prev     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_LOOP_LENGTH:    loop_length    <= cfg.data[LEN_W-1:0];
          CFG_FLIP_THRESHOLD: flip_threshold <= cfg.data;
          CFG_OUTPUT_LEVEL:   output_level   <= cfg.data[LEVEL_W-1:0];
          CFG_RANDOM_SEED:    noise <= (cfg.data == '0) ? SEED_RESET : cfg.data;
          default: ;
        endcase
      end
      if (accept) begin
        pattern    <= pattern_next;
        clock_prev <= samples.clock_level;
        reset_prev <= samples.reset_level;
        if (clk_edge) begin
          noise <= noise_word;
        end
      end
    end
  end

  // sequencer: multiply, then shared compare-subtract divide by mask
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      // the done state reloads the word itself when the receiver takes it
      if (results.ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          rem   <= prod;
          dsr   <= PW'(mask) << (QUOT_W - 1);
          neg   <= output_level[LEVEL_W-1] ^ num_c[NW-1];
          quot  <= '0;
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (rem >= dsr) begin
            rem  <= rem - dsr;
            quot <= {quot[QUOT_W-2:0], 1'b1};
          end else begin
            quot <= {quot[QUOT_W-2:0], 1'b0};
          end
          dsr  <= dsr >> 1;
          step <= step + CW'(1);
          if (step == CW'(QUOT_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || results.ready) begin
            results.bipolar_value <= bip;
            results.scale_bits    <= pat16[SCALE_W-1:0];
            results.gate_value    <= pattern[0] ? output_level : '0;
            results.pattern_bits  <= pat16;
            out_valid             <= 1'b1;
            state                 <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // checks
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_MUL)
    else $error("accepted word did not start the multiply");

  a_load_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result word loaded outside the done state");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE |-> quot <= 16'd32768)
    else $error("quotient exceeds level magnitude");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !samples.ready)
    else $error("input ready while dividing");

endmodule
